// ----- hdl/anqp_3gpp_plmn_list_parser_core_assert.svh -----
// Assertion macros shared by the parser RTL. They vanish in synthesis.
`ifndef ANQP_3GPP_PLMN_LIST_PARSER_CORE_ASSERT_SVH
`define ANQP_3GPP_PLMN_LIST_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define ANQP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Same-cycle implication.
`define ANQP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ANQP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ANQP_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ANQP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ANQP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/anqp_plmn_pkg.sv -----
`default_nettype none
package anqp_plmn_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VERSION = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_COUNT   = 3'd3,
        ST_TRUNC   = 3'd4
    } t_status;

    typedef enum logic {
        KIND_PLMN   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  list_number;
        logic [11:0] country_code;
        logic [11:0] network_code;
        logic        three_digit_mnc;
        t_status     parse_status;
        logic        run_end;
    } t_record;

    // Records produced by one parsed byte: a PLMN first, then the status.
    typedef struct packed {
        logic    plmn_vld;
        logic    stat_vld;
        t_record plmn;
        t_record stat;
    } t_push;

    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] GUD_VERSION   = 8'h00;
    localparam logic [7:0] PLMN_LIST_IEI = 8'h00;
    localparam logic [3:0] MNC_FILLER    = 4'hF;
    localparam logic [8:0] BYTES_MAX     = 9'd511;

endpackage
`default_nettype wire

// ----- hdl/anqp_plmn_parser.sv -----
`default_nettype none
`include "anqp_3gpp_plmn_list_parser_core_assert.svh"
module anqp_plmn_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_last,
    output anqp_plmn_pkg::t_push      o_push
);
    import anqp_plmn_pkg::*;

    typedef enum logic [2:0] {
        PH_VERSION    = 3'd0,
        PH_LENGTH     = 3'd1,
        PH_TYPE       = 3'd2,
        PH_PLMN_SIZE  = 3'd3,
        PH_OTHER_SIZE = 3'd4,
        PH_COUNT      = 3'd5,
        PH_DATA       = 3'd6,
        PH_SKIP       = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_decl_len, n_decl_len;
    logic [8:0]  r_bytes, n_bytes;
    logic [6:0]  r_iei_left, n_iei_left;
    logic [7:0]  r_plmns_left, n_plmns_left;
    logic [1:0]  r_idx, n_idx;
    logic [15:0] r_first, n_first;
    logic [7:0]  r_list, n_list;
    t_status     r_err, n_err;

    t_push       push;
    t_status     end_status;
    logic [9:0]  size_expect;
    logic [11:0] mcc;
    logic [3:0]  mnc_d3;

    assign size_expect = {1'b0, i_byte, 1'b0} + {2'b00, i_byte} + 10'd1;
    assign mcc         = {r_first[11:8], r_first[15:12], r_first[3:0]};
    assign mnc_d3      = r_first[7:4];

    always_comb begin
        n_phase      = r_phase;
        n_decl_len   = r_decl_len;
        n_bytes      = r_bytes;
        n_iei_left   = r_iei_left;
        n_plmns_left = r_plmns_left;
        n_idx        = r_idx;
        n_first      = r_first;
        n_list       = r_list;
        n_err        = r_err;
        end_status   = ST_OK;
        push         = '0;

        if (i_step) begin
            if (r_phase >= PH_TYPE && r_bytes != BYTES_MAX) begin
                n_bytes = r_bytes + 9'd1;
            end

            if (r_err == ST_OK) begin
                case (r_phase)
                    PH_VERSION: begin
                        if (i_byte != GUD_VERSION) begin
                            n_err = ST_VERSION;
                        end
                        n_phase = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        n_decl_len = i_byte;
                        n_phase    = PH_TYPE;
                    end
                    PH_TYPE: begin
                        n_phase = (i_byte == PLMN_LIST_IEI) ? PH_PLMN_SIZE : PH_OTHER_SIZE;
                    end
                    PH_PLMN_SIZE: begin
                        n_iei_left = i_byte[6:0];
                        n_phase    = PH_COUNT;
                    end
                    PH_OTHER_SIZE: begin
                        n_iei_left = i_byte[6:0];
                        n_phase    = (i_byte[6:0] == 7'd0) ? PH_TYPE : PH_SKIP;
                    end
                    PH_COUNT: begin
                        if ({3'b000, r_iei_left} != size_expect) begin
                            n_err = ST_COUNT;
                        end else if (i_byte == 8'd0) begin
                            n_list  = r_list + 8'd1;
                            n_phase = PH_TYPE;
                        end else begin
                            n_plmns_left = i_byte;
                            n_idx        = 2'd0;
                            n_phase      = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (r_idx == 2'd0) begin
                            n_first = {i_byte, 8'h00};
                            n_idx   = 2'd1;
                        end else if (r_idx == 2'd1) begin
                            n_first = {r_first[15:8], i_byte};
                            n_idx   = 2'd2;
                        end else begin
                            push.plmn_vld             = 1'b1;
                            push.plmn.kind            = KIND_PLMN;
                            push.plmn.list_number     = r_list;
                            push.plmn.country_code    = mcc;
                            push.plmn.parse_status    = ST_OK;
                            push.plmn.run_end         = !i_last;
                            if (mnc_d3 != MNC_FILLER) begin
                                push.plmn.network_code    = {i_byte[3:0], i_byte[7:4], mnc_d3};
                                push.plmn.three_digit_mnc = 1'b1;
                            end else begin
                                push.plmn.network_code    = {4'h0, i_byte[3:0], i_byte[7:4]};
                                push.plmn.three_digit_mnc = 1'b0;
                            end
                            n_idx        = 2'd0;
                            n_plmns_left = r_plmns_left - 8'd1;
                            if (r_plmns_left == 8'd1) begin
                                n_list  = r_list + 8'd1;
                                n_phase = PH_TYPE;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_iei_left = r_iei_left - 7'd1;
                        if (r_iei_left == 7'd1) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    default: begin
                        n_phase = PH_VERSION;
                    end
                endcase
            end

            if (i_last) begin
                if (n_err == ST_VERSION) begin
                    end_status = ST_VERSION;
                end else if (n_phase == PH_LENGTH) begin
                    end_status = ST_TRUNC;
                end else if ({1'b0, n_decl_len} != n_bytes) begin
                    end_status = ST_LENGTH;
                end else if (n_err != ST_OK) begin
                    end_status = n_err;
                end else if (n_phase != PH_TYPE) begin
                    end_status = ST_TRUNC;
                end else begin
                    end_status = ST_OK;
                end
                push.stat_vld          = 1'b1;
                push.stat.kind         = KIND_STATUS;
                push.stat.parse_status = end_status;
                push.stat.run_end      = 1'b1;

                n_phase      = PH_VERSION;
                n_decl_len   = 8'd0;
                n_bytes      = 9'd0;
                n_iei_left   = 7'd0;
                n_plmns_left = 8'd0;
                n_idx        = 2'd0;
                n_first      = 16'd0;
                n_list       = 8'd0;
                n_err        = ST_OK;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_VERSION;
            r_decl_len   <= 8'd0;
            r_bytes      <= 9'd0;
            r_iei_left   <= 7'd0;
            r_plmns_left <= 8'd0;
            r_idx        <= 2'd0;
            r_first      <= 16'd0;
            r_list       <= 8'd0;
            r_err        <= ST_OK;
        end else begin
            r_phase      <= n_phase;
            r_decl_len   <= n_decl_len;
            r_bytes      <= n_bytes;
            r_iei_left   <= n_iei_left;
            r_plmns_left <= n_plmns_left;
            r_idx        <= n_idx;
            r_first      <= n_first;
            r_list       <= n_list;
            r_err        <= n_err;
        end
    end

    // The final byte of a payload always returns the parser to a clean start.
    `ANQP_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, i_step && i_last, r_phase == PH_VERSION && r_err == ST_OK && r_bytes == 9'd0)
    // A PLMN only completes on its third data byte.
    `ANQP_ASSERT_IMPLIES(a_plmn_on_third, i_clk, i_rst_n, push.plmn_vld, r_phase == PH_DATA && r_idx == 2'd2)
    // The byte index only moves while inside a PLMN list body.
    `ANQP_ASSERT_IMPLIES(a_idx_idle, i_clk, i_rst_n, r_phase != PH_DATA, r_idx == 2'd0)

endmodule
`default_nettype wire

// ----- hdl/anqp_plmn_fifo.sv -----
`default_nettype none
`include "anqp_3gpp_plmn_list_parser_core_assert.svh"
module anqp_plmn_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire anqp_plmn_pkg::t_push i_push,
    input  wire logic                 i_pop,
    output anqp_plmn_pkg::t_record    o_rec,
    output logic                      o_valid,
    output logic                      o_room
);
    import anqp_plmn_pkg::*;

    t_record                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count, n_count;
    logic [RES_CNT_W-1:0]   push_cnt;
    logic                   pop;
    logic                   any_push;
    logic                   both_push;
    t_record                first_rec;

    assign any_push  = i_push.plmn_vld || i_push.stat_vld;
    assign both_push = i_push.plmn_vld && i_push.stat_vld;
    assign first_rec = i_push.plmn_vld ? i_push.plmn : i_push.stat;
    assign push_cnt  = both_push ? RES_CNT_W'(2) : (any_push ? RES_CNT_W'(1) : '0);
    assign pop       = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(push_cnt);
        n_rd_ptr = pop ? r_rd_ptr + RES_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + push_cnt - (pop ? RES_CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (any_push) begin
            r_mem[r_wr_ptr] <= first_rec;
        end
        if (both_push) begin
            r_mem[r_wr_ptr + RES_PTR_W'(1)] <= i_push.stat;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_rec   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));

    `ANQP_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= RES_CNT_W'(RES_DEPTH))
    // Two records at once only arrive when two slots are free.
    `ANQP_ASSERT_IMPLIES(a_pair_fits, i_clk, i_rst_n, both_push, r_count <= RES_CNT_W'(RES_DEPTH - 2))
    // Occupancy and pointers stay consistent.
    `ANQP_ASSERT_ALWAYS(a_ptr_gap, i_clk, i_rst_n, RES_PTR_W'(r_wr_ptr - r_rd_ptr) == RES_PTR_W'(r_count))

endmodule
`default_nettype wire

// ----- hdl/anqp_3gpp_plmn_list_parser_core.sv -----
// ANQP 3GPP Cellular Network payload parser. Feed the element payload one byte per
// transaction, with i_last_byte set on the final byte. The core checks the GUD version,
// compares the length byte against the bytes that follow it, skips IEIs that are not PLMN
// lists and checks each PLMN list's size against its count. Every complete 3-byte PLMN is
// returned as a record with BCD MCC and MNC (a two-digit MNC reads as 0,d1,d2), and the final
// byte returns a status record. If the status is not zero, the PLMN records of that payload
// should be discarded. One byte is accepted per clock cycle whenever the 4-entry result
// queue has two free slots; a byte yields at most two records, and the queue drains one
// record per cycle, so the sustained rate is one byte per cycle unless the output side
// stalls. A record is written into the result queue before it appears on the output.
`default_nettype none
module anqp_3gpp_plmn_list_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Byte stream in.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_last_byte,
    // Records out.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_record_kind,
    output logic [7:0]       o_list_number,
    output logic [11:0]      o_country_code,
    output logic [11:0]      o_network_code,
    output logic             o_three_digit_mnc,
    output logic [2:0]       o_parse_status,
    output logic             o_run_end
);
    import anqp_plmn_pkg::*;

    t_push   push;
    t_record rec;
    logic    room;
    logic    step;

    // The stall only looks at queue occupancy, so it never depends on the input valid.
    assign o_stall = !room;
    assign step    = i_valid && !o_stall;

    // Parser state advances on every accepted byte and produces the records for it.
    anqp_plmn_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (i_payload_byte),
        .i_last  (i_last_byte),
        .o_push  (push)
    );

    // Result queue decouples the two sides and holds the registered records.
    anqp_plmn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_rec   (rec),
        .o_valid (o_valid),
        .o_room  (room)
    );

    assign o_record_kind     = rec.kind;
    assign o_list_number     = rec.list_number;
    assign o_country_code    = rec.country_code;
    assign o_network_code    = rec.network_code;
    assign o_three_digit_mnc = rec.three_digit_mnc;
    assign o_parse_status    = rec.parse_status;
    assign o_run_end         = rec.run_end;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the ANQP 3GPP Cellular Network PLMN-list parser.
// Payload bytes are queued by the stimulus block and handed to the core by a
// clocked driver. Every accepted transaction is run through a behavioural
// parser kept in this module, which queues the records that byte should
// produce. A clocked monitor takes each record from the core and compares it,
// field by field, with the oldest queued record.
module testbench;
    import anqp_plmn_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TARGET_BYTES = 800;
    localparam int REPORT_CAP   = 200;

    // Phases of the behavioural parser, in the order the payload walks them.
    typedef enum logic [2:0] {
        PARSE_VERSION    = 3'd0,
        PARSE_LENGTH     = 3'd1,
        PARSE_TYPE       = 3'd2,
        PARSE_LIST_SIZE  = 3'd3,
        PARSE_OTHER_SIZE = 3'd4,
        PARSE_COUNT      = 3'd5,
        PARSE_PLMN       = 3'd6,
        PARSE_SKIP       = 3'd7
    } t_parse_phase;

    // One byte waiting to be offered to the core. A set hold_off bit keeps it
    // back until every outstanding record has been seen.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold_off;
    } t_pending_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_payload_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_record_kind;
    logic [7:0]  o_list_number;
    logic [11:0] o_country_code;
    logic [11:0] o_network_code;
    logic        o_three_digit_mnc;
    logic [2:0]  o_parse_status;
    logic        o_run_end;

    t_pending_byte pending_bytes[$];
    t_record       expected_records[$];
    int            queued_bytes = 0;
    int            accepted_bytes = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    // Behavioural parser state.
    t_parse_phase phase;
    logic [7:0]   announced_length;
    logic [8:0]   counted_bytes;
    logic [6:0]   iei_remaining;
    logic [7:0]   plmns_remaining;
    logic [1:0]   plmn_octet;
    logic [15:0]  plmn_head;
    logic [7:0]   list_index;
    t_status      parse_error;

    // Neither side idles while this window of accepted bytes is in flight,
    // so that a long run at full rate is seen as well.
    wire full_rate = (accepted_bytes >= 200) && (accepted_bytes < 500);

    anqp_3gpp_plmn_list_parser_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_payload_byte    (i_payload_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_record_kind     (o_record_kind),
        .o_list_number     (o_list_number),
        .o_country_code    (o_country_code),
        .o_network_code    (o_network_code),
        .o_three_digit_mnc (o_three_digit_mnc),
        .o_parse_status    (o_parse_status),
        .o_run_end         (o_run_end)
    );

    always #6 i_clk = ~i_clk;

    // Returns the parser to the state it holds after reset and after every
    // byte marked last.
    task automatic clear_parser();
        phase            = PARSE_VERSION;
        announced_length = 8'h00;
        counted_bytes    = 9'd0;
        iei_remaining    = 7'd0;
        plmns_remaining  = 8'h00;
        plmn_octet       = 2'd0;
        plmn_head        = 16'h0000;
        list_index       = 8'h00;
        parse_error      = ST_OK;
    endtask

    // Advances the parser by one accepted byte and queues the records it
    // produces: a decoded PLMN when a PLMN's third byte arrives, then the
    // end-of-element status when the byte is marked last.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        t_record    plmn_rec;
        t_record    status_rec;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [3:0] digit3;
        bit         plmn_out;
        plmn_rec   = '0;
        status_rec = '0;
        plmn_out   = 1'b0;

        // Bytes after the length byte are counted even once an error has
        // stopped the parse; the count saturates rather than wrapping.
        if (phase >= PARSE_TYPE && counted_bytes != BYTES_MAX)
            counted_bytes = counted_bytes + 9'd1;

        if (parse_error == ST_OK) begin
            case (phase)
                PARSE_VERSION: begin
                    if (b != GUD_VERSION)
                        parse_error = ST_VERSION;
                    phase = PARSE_LENGTH;
                end
                PARSE_LENGTH: begin
                    announced_length = b;
                    phase = PARSE_TYPE;
                end
                PARSE_TYPE: begin
                    if (b == PLMN_LIST_IEI)
                        phase = PARSE_LIST_SIZE;
                    else
                        phase = PARSE_OTHER_SIZE;
                end
                PARSE_LIST_SIZE: begin
                    iei_remaining = b[6:0];
                    phase = PARSE_COUNT;
                end
                PARSE_OTHER_SIZE: begin
                    iei_remaining = b[6:0];
                    if (b[6:0] == 7'd0)
                        phase = PARSE_TYPE;
                    else
                        phase = PARSE_SKIP;
                end
                PARSE_COUNT: begin
                    if (int'(iei_remaining) != int'(b) * 3 + 1) begin
                        parse_error = ST_COUNT;
                    end else if (b == 8'h00) begin
                        list_index = list_index + 8'd1;
                        phase = PARSE_TYPE;
                    end else begin
                        plmns_remaining = b;
                        plmn_octet = 2'd0;
                        phase = PARSE_PLMN;
                    end
                end
                PARSE_PLMN: begin
                    if (plmn_octet == 2'd0) begin
                        plmn_head = {b, 8'h00};
                        plmn_octet = 2'd1;
                    end else if (plmn_octet == 2'd1) begin
                        plmn_head[7:0] = b;
                        plmn_octet = 2'd2;
                    end else begin
                        // Digits are packed low nibble first in each byte.
                        b0     = plmn_head[15:8];
                        b1     = plmn_head[7:0];
                        digit3 = b1[7:4];
                        plmn_rec.kind         = KIND_PLMN;
                        plmn_rec.list_number  = list_index;
                        plmn_rec.country_code = {b0[3:0], b0[7:4], b1[3:0]};
                        plmn_rec.parse_status = ST_OK;
                        if (digit3 != MNC_FILLER) begin
                            plmn_rec.network_code    = {b[3:0], b[7:4], digit3};
                            plmn_rec.three_digit_mnc = 1'b1;
                        end else begin
                            plmn_rec.network_code    = {4'h0, b[3:0], b[7:4]};
                            plmn_rec.three_digit_mnc = 1'b0;
                        end
                        plmn_out = 1'b1;
                        plmn_octet = 2'd0;
                        plmns_remaining = plmns_remaining - 8'd1;
                        if (plmns_remaining == 8'h00) begin
                            list_index = list_index + 8'd1;
                            phase = PARSE_TYPE;
                        end
                    end
                end
                default: begin
                    iei_remaining = iei_remaining - 7'd1;
                    if (iei_remaining == 7'd0)
                        phase = PARSE_TYPE;
                end
            endcase
        end

        if (last) begin
            // A bad version outranks everything; a payload that stops before
            // its length byte is truncated; then the length check outranks a
            // count error and a cut-off IEI.
            status_rec.kind = KIND_STATUS;
            if (parse_error == ST_VERSION)
                status_rec.parse_status = ST_VERSION;
            else if (phase == PARSE_LENGTH)
                status_rec.parse_status = ST_TRUNC;
            else if ({1'b0, announced_length} != counted_bytes)
                status_rec.parse_status = ST_LENGTH;
            else if (parse_error != ST_OK)
                status_rec.parse_status = parse_error;
            else if (phase != PARSE_TYPE)
                status_rec.parse_status = ST_TRUNC;
            else
                status_rec.parse_status = ST_OK;
            status_rec.run_end = 1'b1;
            clear_parser();
        end else if (plmn_out) begin
            plmn_rec.run_end = 1'b1;
        end

        if (plmn_out)
            expected_records.push_back(plmn_rec);
        if (last)
            expected_records.push_back(status_rec);
    endtask

    function automatic void check_field(input string label, input logic [11:0] want,
                                        input logic [11:0] got);
        if (want !== got) begin
            if (mismatch_count < REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    // Queues one payload; only its final byte carries the last flag.
    task automatic queue_frame(input logic [7:0] frame[$], input bit hold_off);
        t_pending_byte item;
        foreach (frame[i]) begin
            item.data     = frame[i];
            item.last     = (i == frame.size() - 1);
            item.hold_off = hold_off && (i == 0);
            pending_bytes.push_back(item);
            queued_bytes++;
        end
    endtask

    // Directed payloads are written as one hex constant, first byte on the left.
    task automatic directed_frame(input logic [127:0] bytes, input int n, input bit hold_off);
        logic [7:0] frame[$];
        for (int i = n - 1; i >= 0; i--)
            frame.push_back(bytes[8 * i +: 8]);
        queue_frame(frame, hold_off);
    endtask

    // Builds one random payload. Most are well formed with random IEIs and
    // PLMN digits; the rest carry a wrong length, a cut, a bad list size, a
    // bad version, trailing bytes, or are plain noise.
    task automatic random_payload(input bit hold_off);
        logic [7:0] frame[$];
        int flavour;
        int n_iei;
        int bad_iei;
        int count;
        int size;
        int cut;
        flavour = $urandom_range(0, 99);
        if (flavour >= 97) begin
            repeat ($urandom_range(1, 12))
                frame.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (flavour >= 90 && flavour < 94)
                frame.push_back(8'($urandom_range(1, 255)));
            else
                frame.push_back(GUD_VERSION);
            frame.push_back(8'h00);
            n_iei = $urandom_range(0, 4);
            bad_iei = -1;
            if (flavour >= 85 && flavour < 90 && n_iei > 0)
                bad_iei = $urandom_range(0, n_iei - 1);
            for (int i = 0; i < n_iei; i++) begin
                if (i == bad_iei || $urandom_range(0, 9) < 6) begin
                    count = $urandom_range(0, 4);
                    size = count * 3 + 1;
                    if (i == bad_iei)
                        size = (size + $urandom_range(1, 126)) % 128;
                    frame.push_back(PLMN_LIST_IEI);
                    // The top bit of a size byte is not part of the size.
                    frame.push_back({1'($urandom_range(0, 1)), 7'(size)});
                    frame.push_back(8'(count));
                    repeat (count) begin
                        frame.push_back(8'($urandom_range(0, 255)));
                        if ($urandom_range(0, 9) < 3)
                            frame.push_back({MNC_FILLER, 4'($urandom_range(0, 15))});
                        else
                            frame.push_back(8'($urandom_range(0, 255)));
                        frame.push_back(8'($urandom_range(0, 255)));
                    end
                end else begin
                    size = $urandom_range(0, 8);
                    frame.push_back(8'($urandom_range(1, 255)));
                    frame.push_back({1'($urandom_range(0, 1)), 7'(size)});
                    repeat (size)
                        frame.push_back(8'($urandom_range(0, 255)));
                end
            end
            frame[1] = 8'(frame.size() - 2);
            if (flavour >= 70 && flavour < 78)
                frame[1] = frame[1] + 8'($urandom_range(1, 255));
            if (flavour >= 94)
                repeat ($urandom_range(1, 5))
                    frame.push_back(8'($urandom_range(0, 255)));
            if (flavour >= 78 && flavour < 85 && frame.size() > 1) begin
                cut = $urandom_range(1, frame.size() - 1);
                while (frame.size() > cut)
                    void'(frame.pop_back());
            end
        end
        queue_frame(frame, hold_off);
    endtask

    // Driver: offers queued bytes, holding each one until it is accepted.
    // An accepted transaction is handed to the parser at the same edge.
    always @(posedge i_clk) begin
        t_pending_byte next_byte;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                parse_byte(i_payload_byte, i_last_byte);
                accepted_bytes++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() != 0
                        && !(pending_bytes[0].hold_off && expected_records.size() != 0)
                        && (full_rate || $urandom_range(0, 99) >= 10)) begin
                    next_byte = pending_bytes.pop_front();
                    i_valid        <= 1'b1;
                    i_payload_byte <= next_byte.data;
                    i_last_byte    <= next_byte.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every record taken from the core and stalls the
    // output side now and then.
    always @(posedge i_clk) begin
        t_record want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_records.size() == 0) begin
                    if (mismatch_count < REPORT_CAP)
                        $display("%0t: record with none expected, expected nothing, actual %0h",
                                 $time, {o_record_kind, o_list_number, o_country_code,
                                 o_network_code, o_three_digit_mnc, o_parse_status, o_run_end});
                    mismatch_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_kind", 12'(want.kind), 12'(o_record_kind));
                    check_field("list_number", 12'(want.list_number), 12'(o_list_number));
                    check_field("country_code", want.country_code, o_country_code);
                    check_field("network_code", want.network_code, o_network_code);
                    check_field("three_digit_mnc", 12'(want.three_digit_mnc),
                                12'(o_three_digit_mnc));
                    check_field("parse_status", 12'(want.parse_status), 12'(o_parse_status));
                    check_field("run_end", 12'(want.run_end), 12'(o_run_end));
                end
            end
            i_stall <= !full_rate && ($urandom_range(0, 99) < 10);
        end
    end

    // Guards against a hang: a correct run finishes far inside this limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        clear_parser();

        // Directed payloads. A lone version byte is truncated; a non-zero
        // version wins over all else, even on a single byte.
        directed_frame(128'h00, 1, 1'b0);
        directed_frame(128'hFF, 1, 1'b0);
        directed_frame(128'hFF_05, 2, 1'b0);
        // An empty element is fine.
        directed_frame(128'h00_00, 2, 1'b0);
        // One list of two PLMNs, the first with a three-digit MNC and the
        // second with a two-digit one; the last byte gives a PLMN and status.
        directed_frame(128'h00_09_00_07_02_21_43_65_99_F9_99, 11, 1'b1);
        // An empty skipped IEI followed by a list whose size disagrees with
        // its count.
        directed_frame(128'h00_05_05_00_00_05_00, 7, 1'b0);
        // Cut off inside a PLMN with a matching length, then with a length
        // that does not match, which takes precedence.
        directed_frame(128'h00_03_00_04_01, 5, 1'b0);
        directed_frame(128'h00_05_00_04_01, 5, 1'b0);

        // Random payloads, now and then one held back until the core has
        // drained.
        for (int n = 0; queued_bytes < TARGET_BYTES; n++)
            random_payload(n % 20 == 19);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_bytes != queued_bytes)
            @(posedge i_clk);
        while (expected_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_records.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/anqp_plmn_pkg.sv
hdl/anqp_plmn_parser.sv
hdl/anqp_plmn_fifo.sv
hdl/anqp_3gpp_plmn_list_parser_core.sv
bench/testbench.sv
